// ===== hw/rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Command codes, engine state record and phase count lookup.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	typedef enum logic [2:0] {
		CMD_IDLE    = 3'd0,
		CMD_START   = 3'd1,
		CMD_STOP    = 3'd2,
		CMD_WRITE   = 3'd3,
		CMD_WAITACK = 3'd4,
		CMD_READ    = 3'd5,
		CMD_ACK     = 3'd6,
		CMD_NACK    = 3'd7
	} cmd_t;

	localparam logic [5:0] PHASES_WRITE = 6'd24;
	localparam logic [5:0] PHASES_READ  = 6'd19;
	localparam logic [5:0] PHASES_SHORT = 6'd3;
	// Phases of a read that belong to the eight data bits.
	localparam logic [5:0] READ_BIT_PHASES = 6'd16;
	localparam logic [7:0] DELAY_RESET = 8'd5;

	typedef struct packed {
		cmd_t       cmd;
		logic [5:0] phase;
		logic [7:0] tick;
		logic [1:0] sub;     // phase position within a written bit
		logic [7:0] tx;
		logic [7:0] rx;
		logic       nackf;
		logic       scl;
		logic       sda;
		logic       ack;
	} eng_state_t;

	localparam eng_state_t STATE_RESET = '{
		cmd: CMD_IDLE, phase: 6'd0, tick: 8'd0, sub: 2'd0, tx: 8'd0, rx: 8'd0,
		nackf: 1'b0, scl: 1'b1, sda: 1'b1, ack: 1'b0
	};

	function automatic logic [5:0] phase_total(input cmd_t c);
		case (c)
			CMD_WRITE: phase_total = PHASES_WRITE;
			CMD_READ:  phase_total = PHASES_READ;
			default:   phase_total = PHASES_SHORT;
		endcase
	endfunction

endpackage

// ===== hw/rtl/i2c_master_bit_engine.sv =====
// Order: a word accepted into the input register is stepped into the engine state and the
// result register by the next advance, unless the result register is still waiting to be taken.
// Throughput: one word per cycle while the result register is free or being taken; a tick
// is registered, then stepped through the engine state and the result register.
// Reset: arst_n clears the engine to idle with SCL and SDA released, the delay
// register to 5 ticks, and both pipeline valid flags.
// ----------------------------------------------------------------------------
// I2C master bit engine
// Bit-level I2C master, one tick per input word, with an input register, a
// combinational tick step and a result register.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] action,
	input  logic [7:0] tx_byte,
	input  logic       nack_after_read,
	input  logic       sda_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       scl_out,
	output logic       sda_out,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] rx_byte,
	output logic       ack_seen
);

	logic       valid_s1;
	logic [2:0] action_s1;
	logic [7:0] tx_byte_s1;
	logic       nack_s1;
	logic       sda_s1;
	logic [7:0] delay_q;
	logic       advance;
	logic       step_done;
	logic       out_valid_q;
	logic       scl_q;
	logic       sda_q;
	logic       busy_q;
	logic       done_q;
	logic [7:0] rx_q;
	logic       ack_q;

	i2cm_pkg::eng_state_t state_q;
	i2cm_pkg::eng_state_t state_nxt;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	i2cm_step u_step (
		.cur             (state_q),
		.action          (action_s1),
		.tx_byte         (tx_byte_s1),
		.nack_after_read (nack_s1),
		.sda_in          (sda_s1),
		.delay_ticks     (delay_q),
		.nxt             (state_nxt),
		.done            (step_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= i2cm_pkg::DELAY_RESET;
		end else if (cfg_we) begin
			delay_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1  <= action;
			tx_byte_s1 <= tx_byte;
			nack_s1    <= nack_after_read;
			sda_s1     <= sda_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2cm_pkg::STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			scl_q  <= state_nxt.scl;
			sda_q  <= state_nxt.sda;
			busy_q <= (state_nxt.cmd != i2cm_pkg::CMD_IDLE);
			done_q <= step_done;
			rx_q   <= state_nxt.rx;
			ack_q  <= state_nxt.ack;
		end
	end

	assign out_valid = out_valid_q;
	assign scl_out   = scl_q;
	assign sda_out   = sda_q;
	assign busy_res  = busy_q;
	assign done_res  = done_q;
	assign rx_byte   = rx_q;
	assign ack_seen  = ack_q;

`ifndef NO_ASSERTIONS
	// An idle engine always sits at the first tick of the first phase.
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.cmd == i2cm_pkg::CMD_IDLE |-> state_q.phase == 6'd0 && state_q.tick == 8'd0)
		else $error("idle engine holds a stale phase or tick count");

	// The tick count never reaches the phase length while a command runs.
	a_tick_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.cmd != i2cm_pkg::CMD_IDLE && delay_q != 8'd0 |-> state_q.tick < delay_q)
		else $error("tick count ran past the phase length");

	// A finishing word never reports the engine still busy.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(done_res && busy_res))
		else $error("done and busy reported together");

	// Every stepped tick produces a result word at the next edge.
	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("stepped tick left no result word");
`endif

endmodule

// ===== hw/rtl/i2cm_step.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine tick step
// Combinational next-state logic for one tick: command take-over, phase
// entry pin updates, phase exit sampling and phase advance.
// ----------------------------------------------------------------------------
module i2cm_step (
	input  i2cm_pkg::eng_state_t cur,
	input  logic [2:0]           action,
	input  logic [7:0]           tx_byte,
	input  logic                 nack_after_read,
	input  logic                 sda_in,
	input  logic [7:0]           delay_ticks,
	output i2cm_pkg::eng_state_t nxt,
	output logic                 done
);

	logic [7:0] dly;
	logic [7:0] tick_inc;
	logic [5:0] phase_inc;
	logic [5:0] p;
	logic       in_read_bits;

	assign dly = (delay_ticks == 8'd0) ? 8'd1 : delay_ticks;

	always_comb begin
		nxt = cur;
		done = 1'b0;
		tick_inc = '0;
		phase_inc = '0;
		p = '0;
		in_read_bits = 1'b0;

		if (cur.cmd == i2cm_pkg::CMD_IDLE && action != i2cm_pkg::CMD_IDLE) begin
			nxt.cmd = i2cm_pkg::cmd_t'(action);
			nxt.phase = '0;
			nxt.tick = '0;
			nxt.sub = '0;
			nxt.tx = tx_byte;
			nxt.nackf = nack_after_read;
		end

		if (nxt.cmd != i2cm_pkg::CMD_IDLE) begin
			p = nxt.phase;
			in_read_bits = (p < i2cm_pkg::READ_BIT_PHASES);

			// Pins change only on the first tick of a phase.
			if (nxt.tick == 8'd0) begin
				case (nxt.cmd)
					i2cm_pkg::CMD_START: begin
						if (p == 6'd0) begin
							nxt.sda = 1'b1;
							nxt.scl = 1'b1;
						end else if (p == 6'd1) begin
							nxt.sda = 1'b0;
						end else begin
							nxt.scl = 1'b0;
						end
					end
					i2cm_pkg::CMD_STOP: begin
						if (p == 6'd0) begin
							nxt.sda = 1'b0;
							nxt.scl = 1'b0;
						end else if (p == 6'd1) begin
							nxt.scl = 1'b1;
						end else begin
							nxt.sda = 1'b1;
						end
					end
					i2cm_pkg::CMD_WRITE: begin
						if (nxt.sub == 2'd0) begin
							nxt.sda = nxt.tx[7];
							nxt.tx = {nxt.tx[6:0], 1'b0};
						end else if (nxt.sub == 2'd1) begin
							nxt.scl = 1'b1;
						end else begin
							nxt.scl = 1'b0;
						end
					end
					i2cm_pkg::CMD_READ: begin
						if (in_read_bits) begin
							if (p == 6'd0) begin
								nxt.sda = 1'b1;
							end
							nxt.scl = ~p[0];
						end else if (p[1:0] == 2'd0) begin
							// Acknowledge tail after the data bits.
							nxt.sda = nxt.nackf;
						end else if (p[1:0] == 2'd1) begin
							nxt.scl = 1'b1;
						end else begin
							nxt.scl = 1'b0;
						end
					end
					default: begin
						// Wait-ack, ack and nack share the same three-phase tail.
						if (p == 6'd0) begin
							nxt.sda = (nxt.cmd != i2cm_pkg::CMD_ACK);
						end else if (p == 6'd1) begin
							nxt.scl = 1'b1;
						end else begin
							nxt.scl = 1'b0;
						end
					end
				endcase
			end

			tick_inc = nxt.tick + 8'd1;
			if (tick_inc >= dly) begin
				if (nxt.cmd == i2cm_pkg::CMD_WAITACK && p == 6'd1) begin
					nxt.ack = sda_in;
				end else if (nxt.cmd == i2cm_pkg::CMD_READ && in_read_bits && !p[0]) begin
					nxt.rx = {nxt.rx[6:0], sda_in};
				end
				nxt.tick = '0;
				nxt.sub = (nxt.sub == 2'd2) ? 2'd0 : nxt.sub + 2'd1;
				phase_inc = p + 6'd1;
				if (phase_inc >= i2cm_pkg::phase_total(nxt.cmd)) begin
					nxt.cmd = i2cm_pkg::CMD_IDLE;
					nxt.phase = '0;
					done = 1'b1;
				end else begin
					nxt.phase = phase_inc;
				end
			end else begin
				nxt.tick = tick_inc;
			end
		end
	end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives one tick word per handshake into the engine and checks every result
// word against a cycle-exact engine model kept in a small scoreboard. Each
// command is issued only once the model sees the engine idle. The run covers
// directed commands at several delays, then random transfers mixed with
// stray commands, under several sender and receiver stall patterns.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] rx;
		logic       ack;
	} tick_result_t;

	class i2c_tick_scoreboard;
		logic [7:0]     delay_ticks;
		i2cm_pkg::cmd_t cmd;
		logic [5:0]     phase;
		logic [7:0]     tick;
		logic [7:0]     tx_shift;
		logic [7:0]     rx_shift;
		logic           read_nack;
		logic           scl;
		logic           sda;
		logic           ack;
		tick_result_t   levels_q[$];
		int             errors;
		int             ticks;
		int             commands;
		int             completions;

		function new();
			delay_ticks = i2cm_pkg::DELAY_RESET;
			cmd = i2cm_pkg::CMD_IDLE;
			phase = '0;
			tick = '0;
			tx_shift = '0;
			rx_shift = '0;
			read_nack = 1'b0;
			scl = 1'b1;
			sda = 1'b1;
			ack = 1'b0;
			errors = 0;
			ticks = 0;
			commands = 0;
			completions = 0;
		endfunction

		function bit is_idle();
			return cmd == i2cm_pkg::CMD_IDLE;
		endfunction

		function int pending();
			return levels_q.size();
		endfunction

		function void set_delay(logic [7:0] d);
			delay_ticks = d;
		endfunction

		// Acknowledge-style tail: set SDA, raise SCL, lower SCL.
		function void drive_tail(logic [5:0] p, logic level);
			if (p == 0)
				sda = level;
			else if (p == 1)
				scl = 1'b1;
			else
				scl = 1'b0;
		endfunction

		function void enter_phase();
			case (cmd)
			i2cm_pkg::CMD_START: begin
				if (phase == 0) begin
					sda = 1'b1;
					scl = 1'b1;
				end else if (phase == 1)
					sda = 1'b0;
				else
					scl = 1'b0;
			end
			i2cm_pkg::CMD_STOP: begin
				if (phase == 0) begin
					sda = 1'b0;
					scl = 1'b0;
				end else if (phase == 1)
					scl = 1'b1;
				else
					sda = 1'b1;
			end
			i2cm_pkg::CMD_WRITE: begin
				if (phase % 3 == 0) begin
					sda = tx_shift[7];
					tx_shift = tx_shift << 1;
				end else if (phase % 3 == 1)
					scl = 1'b1;
				else
					scl = 1'b0;
			end
			i2cm_pkg::CMD_READ: begin
				// Data phases alternate SCL high and low; SDA is released once.
				if (phase < i2cm_pkg::READ_BIT_PHASES) begin
					if (phase == 0)
						sda = 1'b1;
					scl = ~phase[0];
				end else
					drive_tail(phase - i2cm_pkg::READ_BIT_PHASES, read_nack);
			end
			i2cm_pkg::CMD_WAITACK, i2cm_pkg::CMD_NACK: drive_tail(phase, 1'b1);
			i2cm_pkg::CMD_ACK: drive_tail(phase, 1'b0);
			default: ;
			endcase
		endfunction

		function void note_tick(i2cm_pkg::cmd_t act, logic [7:0] txb, logic nack,
			logic sda_in);
			logic [7:0]   hold;
			logic [5:0]   last;
			tick_result_t r;
			hold = (delay_ticks == 0) ? 8'd1 : delay_ticks;
			r = '0;
			ticks++;
			if (cmd == i2cm_pkg::CMD_IDLE && act != i2cm_pkg::CMD_IDLE) begin
				cmd = act;
				phase = '0;
				tick = '0;
				tx_shift = txb;
				read_nack = nack;
				commands++;
			end
			if (cmd != i2cm_pkg::CMD_IDLE) begin
				if (tick == 0)
					enter_phase();
				tick++;
				if (tick >= hold) begin
					// SDA is sampled on the last tick of an SCL-high phase.
					if (cmd == i2cm_pkg::CMD_WAITACK && phase == 1)
						ack = sda_in;
					else if (cmd == i2cm_pkg::CMD_READ && phase < i2cm_pkg::READ_BIT_PHASES &&
						!phase[0])
						rx_shift = {rx_shift[6:0], sda_in};
					tick = '0;
					phase++;
					last = (cmd == i2cm_pkg::CMD_WRITE) ? i2cm_pkg::PHASES_WRITE :
						(cmd == i2cm_pkg::CMD_READ) ? i2cm_pkg::PHASES_READ :
						i2cm_pkg::PHASES_SHORT;
					if (phase >= last) begin
						cmd = i2cm_pkg::CMD_IDLE;
						phase = '0;
						r.done = 1'b1;
						completions++;
					end
				end
			end
			r.scl = scl;
			r.sda = sda;
			r.busy = (cmd != i2cm_pkg::CMD_IDLE);
			r.rx = rx_shift;
			r.ack = ack;
			levels_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_tick(tick_result_t got);
			tick_result_t want;
			if (levels_q.size() == 0) begin
				$error("result word arrived with no expectation waiting");
				errors++;
				return;
			end
			want = levels_q.pop_front();
			compare_field("scl_out", want.scl, got.scl);
			compare_field("sda_out", want.sda, got.sda);
			compare_field("busy_res", want.busy, got.busy);
			compare_field("done_res", want.done, got.done);
			compare_field("rx_byte", want.rx, got.rx);
			compare_field("ack_seen", want.ack, got.ack);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [2:0] action = 3'd0;
	logic [7:0] tx_byte = 8'd0;
	logic       nack_after_read = 1'b0;
	logic       sda_in = 1'b1;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       scl_out;
	logic       sda_out;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_seen;

	i2c_tick_scoreboard sb = new();
	int idle_mode = 0;
	bit hold_off_request = 1'b0;

	i2c_master_bit_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.tx_byte(tx_byte),
		.nack_after_read(nack_after_read),
		.sda_in(sda_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.scl_out(scl_out),
		.sda_out(sda_out),
		.busy_res(busy_res),
		.done_res(done_res),
		.rx_byte(rx_byte),
		.ack_seen(ack_seen)
	);

	always #2 clk = ~clk;

	initial begin
		#4000000;
		$display("Verification failed");
		$finish;
	end

	// Receiver: random stalls per idle mode, plus one long hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off_request) begin
				out_ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_off_request = 1'b0;
			end else
				out_ready <= !((idle_mode == 2 && $urandom_range(0, 99) < 50) ||
					(idle_mode == 3 && $urandom_range(0, 99) < 8));
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_tick(tick_result_t'({scl_out, sda_out, busy_res, done_res, rx_byte,
				ack_seen}));
	end

	// Offers one tick word and returns at the edge where it is accepted.
	task automatic send_tick(i2cm_pkg::cmd_t act, logic [7:0] txb, logic nack,
		logic sda_bit);
		@(negedge clk);
		while ((idle_mode == 1 && $urandom_range(0, 99) < 50) ||
			(idle_mode == 3 && $urandom_range(0, 99) < 8)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		tx_byte <= txb;
		nack_after_read <= nack;
		sda_in <= sda_bit;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_tick(act, txb, nack, sda_bit);
	endtask

	// Issues a command while idle, then keeps ticking until it completes.
	// Commands offered during the busy ticks must be ignored.
	task automatic issue(i2cm_pkg::cmd_t c, logic [7:0] b, logic n);
		repeat ($urandom_range(0, 2))
			send_tick(i2cm_pkg::CMD_IDLE, 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		send_tick(c, b, n, 1'($urandom_range(0, 1)));
		while (!sb.is_idle())
			send_tick(i2cm_pkg::cmd_t'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	task automatic write_delay(logic [7:0] d);
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_delay(d);
	endtask

	// One bus transfer: start, address, then maybe a data byte, maybe a
	// stray acknowledge, and stop.
	task automatic run_transfer();
		int count;
		bit reading;
		count = $urandom_range(0, 1);
		reading = 1'($urandom_range(0, 1));
		issue(i2cm_pkg::CMD_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		issue(i2cm_pkg::CMD_WRITE, {7'($urandom_range(0, 127)), reading},
			1'($urandom_range(0, 1)));
		issue(i2cm_pkg::CMD_WAITACK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		for (int k = 0; k < count; k++) begin
			if (reading)
				issue(i2cm_pkg::CMD_READ, 8'($urandom_range(0, 255)), k == count - 1);
			else begin
				issue(i2cm_pkg::CMD_WRITE, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
				issue(i2cm_pkg::CMD_WAITACK, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end
		end
		if ($urandom_range(0, 3) == 0)
			issue($urandom_range(0, 1) ? i2cm_pkg::CMD_ACK : i2cm_pkg::CMD_NACK,
				8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		issue(i2cm_pkg::CMD_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	// Runs random traffic until about target tick words have been sent.
	task automatic run_phase(int mode, logic [7:0] d, int target, bit hold_off);
		int start_count;
		write_delay(d);
		idle_mode = mode;
		hold_off_request = hold_off;
		start_count = sb.ticks;
		while (sb.ticks - start_count < target) begin
			if ($urandom_range(0, 3) == 0)
				run_transfer();
			else
				issue(i2cm_pkg::cmd_t'($urandom_range(1, 7)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset delay, then the fastest, a long and the zero delay.
		issue(i2cm_pkg::CMD_START, 8'h00, 1'b0);
		issue(i2cm_pkg::CMD_STOP, 8'h00, 1'b0);
		repeat (3) send_tick(i2cm_pkg::CMD_IDLE, 8'hFF, 1'b1, 1'b0);
		write_delay(8'd1);
		issue(i2cm_pkg::CMD_START, 8'h00, 1'b0);
		issue(i2cm_pkg::CMD_WRITE, 8'h00, 1'b0);
		issue(i2cm_pkg::CMD_WAITACK, 8'h00, 1'b0);
		issue(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b1);
		issue(i2cm_pkg::CMD_WAITACK, 8'hFF, 1'b1);
		issue(i2cm_pkg::CMD_WRITE, 8'hA5, 1'b0);
		issue(i2cm_pkg::CMD_READ, 8'h00, 1'b0);
		issue(i2cm_pkg::CMD_READ, 8'hFF, 1'b1);
		issue(i2cm_pkg::CMD_ACK, 8'h00, 1'b0);
		issue(i2cm_pkg::CMD_NACK, 8'hFF, 1'b1);
		issue(i2cm_pkg::CMD_STOP, 8'h00, 1'b0);
		write_delay(8'd25);
		issue(i2cm_pkg::CMD_WAITACK, 8'h00, 1'b0);
		write_delay(8'd0);
		issue(i2cm_pkg::CMD_WRITE, 8'h3C, 1'b0);

		// Random traffic; the first phase also holds the output off for a while.
		run_phase(0, 8'd1, 55, 1'b1);
		run_phase(1, 8'd2, 55, 1'b0);
		run_phase(2, 8'd1, 55, 1'b0);
		run_phase(3, 8'd1, 55, 1'b0);

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Run covered %0d tick words, %0d commands and %0d completions",
			sb.ticks, sb.commands, sb.completions);
		$display("at delays of 0, 1, 2, 5 and 25 ticks, with sender gaps and receiver stalls.");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
